>>> rtl/core/triangular_matrix_product_assert.svh
// Assertion macros used by the triangular matrix product top level
`ifndef TRIANGULAR_MATRIX_PRODUCT_ASSERT_SVH
`define TRIANGULAR_MATRIX_PRODUCT_ASSERT_SVH

// checked only outside reset
`define TRMM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TRMM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/trmm_pkg.sv
// Shared constants, codes and types of the triangular matrix product block
package trmm_pkg;

    localparam int MAX_ORDER = 8;
    localparam int IDX_W     = 3;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
    localparam int SIZE_W    = 4;

    localparam int AB_W      = 16;
    localparam int C_W       = 32;
    localparam int SUM_W     = 35;              // eight Q16.16 products, exact
    localparam int PROD_W    = SUM_W + AB_W;    // sum times alpha, Q27.24
    localparam int FRAC_SH   = 16;

    localparam logic signed [AB_W-1:0]   ONE_Q8   = 16'sd256;
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(32768);

    // opcodes
    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_LOAD_C = 2'd2;
    localparam logic [1:0] OP_START  = 2'd3;

    // register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_A_UNIT_DIAG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_UNIT_DIAG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCUMULATE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 3'd5;
    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic mul_en;     // capture multiplier output
        logic use_scale;  // multiply running sum by alpha instead of A*B
        logic acc_clr;    // zero running sum
        logic acc_en;     // add captured product into running sum
    } t_mac_ctl;

endpackage

>>> rtl/core/triangular_matrix_product.sv
// Top level: element stores, sequencer and result register of the triangular product
//
//  channel  dir  handshake                  beat contents
//  in       in   i_in_valid / o_in_stall    opcode, row, col, element value
//  out      out  o_out_valid / i_out_stall  row, col, saturated value, last flag
//  cfg      in   i_cfg_we (no stall)        register index, 16-bit data
//
// Loads are accepted while idle. A start emits N*N results, one element (i,j)
// at a time on the one shared multiplier, T being its term count
// (N-max(i,j) upper-times-lower, min(i,j)+1 lower-times-upper); a result also
// waits while the previous one is held by i_out_stall. The input is stalled from
// start to the hand-over of the last result. Synchronous reset clears the
// configuration, sequencer and output valid; the stores hold nothing defined until written.
`include "triangular_matrix_product_assert.svh"

module triangular_matrix_product (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_opcode,
    input  logic [trmm_pkg::IDX_W-1:0]           i_row_index,
    input  logic [trmm_pkg::IDX_W-1:0]           i_col_index,
    input  logic signed [trmm_pkg::C_W-1:0]      i_element_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [trmm_pkg::IDX_W-1:0]           o_out_row,
    output logic [trmm_pkg::IDX_W-1:0]           o_out_col,
    output logic signed [trmm_pkg::C_W-1:0]      o_out_value,
    output logic                                 o_last_flag,
    input  logic                                 i_cfg_we,
    input  logic [trmm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [trmm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import trmm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_SCALE = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    // configuration
    logic [SIZE_W-1:0]      r_matrix_size;
    logic                   r_order_mode;
    logic                   r_a_unit;
    logic                   r_b_unit;
    logic                   r_accumulate;
    logic signed [AB_W-1:0] r_scale;

    // sequencer
    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic             r_v1, n_v1, r_v2;
    logic             r_a_one, n_a_one, r_b_one, n_b_one;

    // result register
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_row, r_out_col;
    logic [C_W-1:0]   r_out_value;
    logic             r_out_last;

    logic             in_acc, load_acc, out_load;
    logic [SIZE_W-1:0] n_eff, n_eff_m1;
    logic [IDX_W-1:0] n_last, k_hi, min_ij;
    logic             elem_last;
    t_mac_ctl         mac_ctl;

    logic [AB_W-1:0]          a_rdata, b_rdata;
    logic [C_W-1:0]           c_rdata;
    logic signed [AB_W-1:0]   a_op, b_op;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rnd;
    logic signed [SUM_W-1:0]  p_val;
    logic signed [SUM_W:0]    total;
    logic [C_W-1:0]           res;
    logic                     c_we;
    logic [ADDR_W-1:0]        c_waddr;
    logic [C_W-1:0]           c_wdata;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign load_acc   = in_acc && (i_opcode != OP_START);
    assign o_in_stall = (r_state != S_IDLE);

    // effective order, clamped into 1..MAX_ORDER
    always_comb begin
        if (r_matrix_size == '0) begin
            n_eff = SIZE_W'(1);
        end else if (r_matrix_size > SIZE_W'(MAX_ORDER)) begin
            n_eff = SIZE_W'(MAX_ORDER);
        end else begin
            n_eff = r_matrix_size;
        end
    end
    assign n_eff_m1  = n_eff - SIZE_W'(1);
    assign n_last    = n_eff_m1[IDX_W-1:0];
    assign min_ij    = (r_i < r_j) ? r_i : r_j;
    assign k_hi      = r_order_mode ? min_ij : n_last;
    assign elem_last = (r_i == n_last) && (r_j == n_last);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= SIZE_W'(MAX_ORDER);
            r_order_mode  <= 1'b0;
            r_a_unit      <= 1'b0;
            r_b_unit      <= 1'b0;
            r_accumulate  <= 1'b0;
            r_scale       <= ONE_Q8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MATRIX_SIZE: r_matrix_size <= i_cfg_data[SIZE_W-1:0];
                CFG_ORDER_MODE:  r_order_mode  <= i_cfg_data[0];
                CFG_A_UNIT_DIAG: r_a_unit      <= i_cfg_data[0];
                CFG_B_UNIT_DIAG: r_b_unit      <= i_cfg_data[0];
                CFG_ACCUMULATE:  r_accumulate  <= i_cfg_data[0];
                CFG_SCALE:       r_scale       <= $signed(i_cfg_data[AB_W-1:0]);
                default: ;
            endcase
        end
    end

    // stores
    trmm_ram #(.WIDTH(AB_W), .DEPTH(DEPTH)) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (load_acc && (i_opcode == OP_LOAD_A)),
        .i_waddr ({i_row_index, i_col_index}),
        .i_wdata (i_element_value[AB_W-1:0]),
        .i_raddr ({r_i, r_k}),
        .o_rdata (a_rdata)
    );

    trmm_ram #(.WIDTH(AB_W), .DEPTH(DEPTH)) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (load_acc && (i_opcode == OP_LOAD_B)),
        .i_waddr ({i_row_index, i_col_index}),
        .i_wdata (i_element_value[AB_W-1:0]),
        .i_raddr ({r_k, r_j}),
        .o_rdata (b_rdata)
    );

    assign c_we    = (load_acc && (i_opcode == OP_LOAD_C)) || out_load;
    assign c_waddr = (r_state == S_IDLE) ? {i_row_index, i_col_index} : {r_i, r_j};
    assign c_wdata = (r_state == S_IDLE) ? i_element_value : res;

    trmm_ram #(.WIDTH(C_W), .DEPTH(DEPTH)) u_c_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr ({r_i, r_j}),
        .o_rdata (c_rdata)
    );

    // unit diagonal replaces the stored value
    assign a_op = r_a_one ? ONE_Q8 : $signed(a_rdata);
    assign b_op = r_b_one ? ONE_Q8 : $signed(b_rdata);

    trmm_mac u_mac (
        .i_clk   (i_clk),
        .i_ctl   (mac_ctl),
        .i_a     (a_op),
        .i_b     (b_op),
        .i_alpha (r_scale),
        .o_prod  (prod)
    );

    // round to nearest (ties up), add C when accumulating, saturate
    always_comb begin
        rnd   = prod + RND_HALF;
        p_val = rnd[PROD_W-1:FRAC_SH];
        total = {p_val[SUM_W-1], p_val};
        if (r_accumulate) begin
            total = total + (SUM_W+1)'($signed(c_rdata));
        end
        if (total[SUM_W:C_W-1] != '0 && total[SUM_W:C_W-1] != '1) begin
            res = total[SUM_W] ? {1'b1, {(C_W-1){1'b0}}} : {1'b0, {(C_W-1){1'b1}}};
        end else begin
            res = total[C_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_v1     = 1'b0;
        n_a_one  = r_a_one;
        n_b_one  = r_b_one;
        out_load = 1'b0;
        mac_ctl  = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_opcode == OP_START)) begin
                    n_state         = S_MAC;
                    n_i             = '0;
                    n_j             = '0;
                    n_k             = '0;
                    mac_ctl.acc_clr = 1'b1;
                end
            end
            S_MAC: begin
                n_v1    = 1'b1;
                n_a_one = r_a_unit && (r_k == r_i);
                n_b_one = r_b_unit && (r_k == r_j);
                if (r_k == k_hi) begin
                    n_state = S_WAIT;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            S_WAIT: begin
                if (!r_v1 && !r_v2) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                mac_ctl.use_scale = 1'b1;
                mac_ctl.mul_en    = 1'b1;
                n_state           = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    if (elem_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state         = S_MAC;
                        mac_ctl.acc_clr = 1'b1;
                        if (r_j == n_last) begin
                            n_j = '0;
                            n_i = r_i + IDX_W'(1);
                        end else begin
                            n_j = r_j + IDX_W'(1);
                        end
                        // lower bound of k: max(i,j) upper-times-lower, else 0
                        n_k = r_order_mode ? '0 : ((n_i > n_j) ? n_i : n_j);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        mac_ctl.mul_en = mac_ctl.mul_en | r_v1;
        mac_ctl.acc_en = r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_v1    <= n_v1;
            r_v2    <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_one <= n_a_one;
        r_b_one <= n_b_one;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_row   <= r_i;
            r_out_col   <= r_j;
            r_out_value <= res;
            r_out_last  <= elem_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = $signed(r_out_value);
    assign o_last_flag = r_out_last;

    `TRMM_ASSERT_ALWAYS(a_reset_idle, i_clk,
        !i_rst_n |=> (r_state == S_IDLE) && !o_out_valid, "reset left block busy")
    `TRMM_ASSERT(a_scale_after_drain, i_clk, i_rst_n,
        (r_state == S_SCALE) |-> (!r_v1 && !r_v2), "alpha scaling overlaps a product term")
    `TRMM_ASSERT(a_k_in_range, i_clk, i_rst_n,
        (r_state == S_MAC) |-> (r_k <= k_hi), "term index beyond triangle")
    `TRMM_ASSERT(a_load_from_out, i_clk, i_rst_n,
        $rose(o_out_valid) |-> $past(r_state == S_OUT), "result beat raised outside output state")
    `TRMM_ASSERT(a_last_ends, i_clk, i_rst_n,
        (out_load && elem_last) |=> (r_state == S_IDLE), "last element did not end the run")

endmodule

>>> rtl/core/trmm_ram.sv
// Generic single-write, single-read RAM with registered read data
module trmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/trmm_mac.sv
// Shared multiplier and accumulator: A*B terms, then the alpha scaling
module trmm_mac (
    input  logic                                i_clk,
    input  trmm_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [trmm_pkg::AB_W-1:0]    i_a,
    input  logic signed [trmm_pkg::AB_W-1:0]    i_b,
    input  logic signed [trmm_pkg::AB_W-1:0]    i_alpha,
    output logic signed [trmm_pkg::PROD_W-1:0]  o_prod
);
    import trmm_pkg::*;

    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  mul_x;
    logic signed [AB_W-1:0]   mul_y;
    logic signed [PROD_W-1:0] mul_p;

    assign mul_x = i_ctl.use_scale ? r_sum : SUM_W'(i_a);
    assign mul_y = i_ctl.use_scale ? i_alpha : i_b;
    assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

    always_comb begin
        n_sum = r_sum;
        if (i_ctl.acc_clr) begin
            n_sum = '0;
        end else if (i_ctl.acc_en) begin
            // a single A*B term fits well inside the sum width
            n_sum = r_sum + r_prod[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        if (i_ctl.mul_en) begin
            r_prod <= mul_p;
        end
    end

    assign o_prod = r_prod;

endmodule
